// ----- sv/smmc_pkg.sv -----
// shared types and constants of the shutter motor move controller
package smmc_pkg;

	// request kinds carried in tuser
	localparam logic [2:0] REQ_TICK   = 3'd0;
	localparam logic [2:0] REQ_UP     = 3'd1;
	localparam logic [2:0] REQ_DOWN   = 3'd2;
	localparam logic [2:0] REQ_PULSE  = 3'd3;
	localparam logic [2:0] REQ_TARGET = 3'd4;

	// event codes
	localparam logic [2:0] EV_NONE       = 3'd0;
	localparam logic [2:0] EV_STOP       = 3'd1;
	localparam logic [2:0] EV_MAX_TIME   = 3'd2;
	localparam logic [2:0] EV_PULSE_LOST = 3'd3;
	localparam logic [2:0] EV_TARGET     = 3'd4;
	localparam logic [2:0] EV_START_UP   = 3'd5;
	localparam logic [2:0] EV_START_DOWN = 3'd6;

	// motion directions
	localparam logic signed [1:0] DIR_DOWN = -2'sd1;
	localparam logic signed [1:0] DIR_STOP = 2'sd0;
	localparam logic signed [1:0] DIR_UP   = 2'sd1;

	// register indexes
	localparam logic [2:0] REG_MAX_MOVE   = 3'd0;
	localparam logic [2:0] REG_PULSE_GAP  = 3'd1;
	localparam logic [2:0] REG_STOP_DELAY = 3'd2;
	localparam logic [2:0] REG_REBOOT     = 3'd3;
	localparam logic [2:0] REG_START_POS  = 3'd4;

	localparam logic [23:0] MAX_MOVE_RST   = 24'd60000;
	localparam logic [23:0] PULSE_GAP_RST  = 24'd3000;
	localparam logic [15:0] STOP_DELAY_RST = 16'd500;
	localparam logic [31:0] REBOOT_RST     = 32'hFFFF_FFFF;
	localparam logic signed [15:0] START_POS_RST = 16'sd0;

	localparam logic [15:0] LONG_PRESS_MS    = 16'd2000;
	localparam logic [2:0]  LONG_PRESS_LIMIT = 3'd3;
	localparam logic [2:0]  LONG_PRESS_MAX   = 3'd7;
	localparam logic signed [15:0] NO_TARGET = -16'sd1;

	typedef struct packed {
		logic [23:0]        max_move_ms;
		logic [23:0]        max_pulse_gap_ms;
		logic [15:0]        stop_delay_ms;
		logic [31:0]        reboot_after_ms;
		logic signed [15:0] start_position;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic [31:0]        move_start_ms;
		logic [31:0]        last_pulse_ms;
		logic [31:0]        stop_time_ms;
		logic signed [1:0]  cur_dir;
		logic signed [1:0]  want_dir;
		logic signed [15:0] goal_pos;
		logic signed [15:0] pos_count;
		logic [2:0]         long_press_count;
	} state_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [15:0]        hold_ms;
		logic signed [15:0] target_pos;
	} item_t;

	// declared highest field first so the packed form matches tdata
	typedef struct packed {
		logic               reboot_request;
		logic [2:0]         event_code;
		logic signed [15:0] position;
		logic signed [1:0]  moving_dir;
		logic               dir_down;
		logic               power_on;
	} result_t;

endpackage

// ----- sv/smmc_cfg.sv -----
// configuration registers behind the apb-style port
module smmc_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output smmc_pkg::cfg_t      cfg,
	output logic                pos_load
);
	import smmc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[4:2];
	assign wr_en    = psel & penable & pwrite & pready;
	assign pos_load = wr_en && (reg_idx == REG_START_POS);
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_move_ms      <= MAX_MOVE_RST;
			cfg_q.max_pulse_gap_ms <= PULSE_GAP_RST;
			cfg_q.stop_delay_ms    <= STOP_DELAY_RST;
			cfg_q.reboot_after_ms  <= REBOOT_RST;
			cfg_q.start_position   <= START_POS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAX_MOVE:   cfg_q.max_move_ms      <= pwdata[23:0];
				REG_PULSE_GAP:  cfg_q.max_pulse_gap_ms <= pwdata[23:0];
				REG_STOP_DELAY: cfg_q.stop_delay_ms    <= pwdata[15:0];
				REG_REBOOT:     cfg_q.reboot_after_ms  <= pwdata;
				REG_START_POS:  cfg_q.start_position   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_MOVE:   prdata = {8'd0, cfg_q.max_move_ms};
			REG_PULSE_GAP:  prdata = {8'd0, cfg_q.max_pulse_gap_ms};
			REG_STOP_DELAY: prdata = {16'd0, cfg_q.stop_delay_ms};
			REG_REBOOT:     prdata = cfg_q.reboot_after_ms;
			REG_START_POS:  prdata = {16'd0, cfg_q.start_position};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// ----- sv/smmc_step.sv -----
// event handling and move rule for one item, purely combinational
module smmc_step (
	input  smmc_pkg::cfg_t   cfg,
	input  smmc_pkg::state_t st,
	input  smmc_pkg::item_t  item,
	output smmc_pkg::state_t nxt,
	output smmc_pkg::result_t res
);
	import smmc_pkg::*;

	logic [31:0]        now1;
	logic [31:0]        last1;
	logic signed [15:0] pos1;
	logic signed [15:0] goal1;
	logic signed [1:0]  want1;
	logic [2:0]         lpc1;
	logic [31:0]        run_ms;
	logic [31:0]        quiet_ms;
	logic [31:0]        rest_ms;
	logic [31:0]        gap_lim;
	logic               moving;
	logic               halt;
	logic               start;
	logic               reboot;
	logic [2:0]         ev;

	always_comb begin
		moving = (st.cur_dir != DIR_STOP);
		now1   = st.now_ms;
		last1  = st.last_pulse_ms;
		pos1   = st.pos_count;
		goal1  = st.goal_pos;
		want1  = st.want_dir;
		lpc1   = st.long_press_count;

		// apply the event first
		case (item.req_type)
			REQ_TICK: now1 = st.now_ms + 32'd1;
			REQ_UP: begin
				if (item.hold_ms > LONG_PRESS_MS) begin
					if (st.long_press_count != LONG_PRESS_MAX)
						lpc1 = st.long_press_count + 3'd1;
				end else begin
					lpc1  = 3'd0;
					want1 = moving ? DIR_STOP : DIR_UP;
					goal1 = NO_TARGET;
				end
			end
			REQ_DOWN: begin
				want1 = moving ? DIR_STOP : DIR_DOWN;
				goal1 = NO_TARGET;
			end
			REQ_PULSE: begin
				if (moving)
					pos1 = st.pos_count + {{14{st.cur_dir[1]}}, st.cur_dir};
				last1 = st.now_ms;
			end
			REQ_TARGET: begin
				goal1 = item.target_pos;
				want1 = (st.pos_count > item.target_pos) ? DIR_DOWN : DIR_UP;
			end
			default: ;
		endcase

		reboot = (lpc1 > LONG_PRESS_LIMIT) ||
			(st.cur_dir == DIR_STOP && want1 == DIR_STOP && now1 > cfg.reboot_after_ms);

		// elapsed times wrap modulo 2^32
		run_ms   = now1 - st.move_start_ms;
		quiet_ms = now1 - last1;
		rest_ms  = now1 - st.stop_time_ms;
		gap_lim  = {8'd0, cfg.max_pulse_gap_ms};

		halt  = 1'b0;
		start = 1'b0;
		ev    = EV_NONE;
		if (moving && run_ms > {8'd0, cfg.max_move_ms}) begin
			halt = 1'b1;
			ev   = EV_MAX_TIME;
		end else if (moving && run_ms > gap_lim && quiet_ms > gap_lim) begin
			halt = 1'b1;
			ev   = EV_PULSE_LOST;
		end else if (moving && goal1 != NO_TARGET &&
				((want1 == DIR_DOWN && pos1 <= goal1) ||
				(want1 == DIR_UP && pos1 >= goal1))) begin
			halt = 1'b1;
			ev   = EV_TARGET;
		end else if (want1 == st.cur_dir) begin
			ev = EV_NONE;
		end else if (want1 == DIR_STOP) begin
			halt = 1'b1;
			ev   = EV_STOP;
		end else if (rest_ms < {16'd0, cfg.stop_delay_ms}) begin
			ev = EV_NONE;
		end else begin
			start = 1'b1;
			ev    = (want1 == DIR_UP) ? EV_START_UP : EV_START_DOWN;
		end

		nxt.now_ms           = now1;
		nxt.move_start_ms    = st.move_start_ms;
		nxt.last_pulse_ms    = last1;
		nxt.stop_time_ms     = st.stop_time_ms;
		nxt.cur_dir          = st.cur_dir;
		nxt.want_dir         = want1;
		nxt.goal_pos         = goal1;
		nxt.pos_count        = pos1;
		nxt.long_press_count = lpc1;
		if (halt) begin
			nxt.cur_dir      = DIR_STOP;
			nxt.want_dir     = DIR_STOP;
			nxt.stop_time_ms = now1;
		end
		if (start) begin
			nxt.cur_dir       = want1;
			nxt.move_start_ms = now1;
		end

		res.power_on       = (nxt.cur_dir != DIR_STOP);
		res.dir_down       = (nxt.cur_dir == DIR_DOWN);
		res.moving_dir     = nxt.cur_dir;
		res.position       = pos1;
		res.event_code     = ev;
		res.reboot_request = reboot;
	end

endmodule

// ----- sv/shutter_motor_move_controller.sv -----
// top level of the shutter motor move controller
// Takes one request beat per clock on the input stream: a 1 ms tick, an up or
// down button release, a reed position pulse or a target position. Each beat is
// registered, then the event and the move rule are evaluated against the
// controller state and the result beat is written to the output register;
// one beat per cycle is sustained while the output side keeps taking results.
// The output register lets a new request enter while a finished result waits.
// The configuration port is an apb-style slave with registers at byte offsets
// 0x00 max_move_ms, 0x04 max_pulse_gap_ms, 0x08 stop_delay_ms,
// 0x0c reboot_after_ms, 0x10 start_position; writing start_position also
// loads the position count. Write registers only while the stream is idle.
module shutter_motor_move_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // hold_ms [15:0], target_pos [31:16]
	input  logic [2:0]  s_axis_tuser,  // req_type [2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// power_on [0], dir_down [1], moving_dir [3:2], position [19:4],
	// event_code [22:20], reboot_request [23]
	output logic [23:0] m_axis_tdata
);
	import smmc_pkg::*;

	cfg_t    cfg;
	logic    pos_load;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_nxt;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;

	smmc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg      (cfg),
		.pos_load (pos_load)
	);

	smmc_step u_step (
		.cfg  (cfg),
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.req_type   <= s_axis_tuser;
			item_s1.hold_ms    <= s_axis_tdata[15:0];
			item_s1.target_pos <= s_axis_tdata[31:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= res_nxt;
	end

	// controller state moves on with every beat that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.now_ms           <= 32'd0;
			state_q.move_start_ms    <= 32'd0;
			state_q.last_pulse_ms    <= 32'd0;
			state_q.stop_time_ms     <= 32'd0;
			state_q.cur_dir          <= DIR_STOP;
			state_q.want_dir         <= DIR_STOP;
			state_q.goal_pos         <= NO_TARGET;
			state_q.pos_count        <= START_POS_RST;
			state_q.long_press_count <= 3'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end else if (pos_load) begin
			state_q.pos_count <= pwdata[15:0];
		end
	end

endmodule
